[rtl/matrix_multiply_engine_assert.svh]
// Assertion macros shared by the matrix multiply engine checkers.
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define MME_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define MME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mme_pkg.sv]
// Shared types, constants and helpers of the matrix multiply engine.
package mme_pkg;

	localparam int DEF_MAX_DIM = 8;
	localparam int IDX_LIMIT   = 8;   // what a 3-bit index can name
	localparam int IDX_W       = 3;
	localparam int DIM_W       = 4;
	localparam int VAL_W       = 16;
	localparam int PROD_W      = 32;
	localparam int SUM_W       = 35;
	localparam int FUNC_W      = 2;
	localparam int CFG_IDX_W   = 2;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_LEFT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_RIGHT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_LENGTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLUMNS = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	// Tag that travels with each term through the multiply-accumulate pipe.
	typedef struct packed {
		logic             first;    // first term of an element
		logic             last_k;   // last term of an element
		logic             last_el;  // element is the last of the run
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} term_tag_t;

	// Zero counts as one, anything above the limit is clipped to it.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] dim,
			input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] res;
		if (dim == '0) begin
			res = 4'd1;
		end else if (dim > lim) begin
			res = lim;
		end else begin
			res = dim;
		end
		return res;
	endfunction

endpackage

[rtl/mme_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/mme_mac.sv]
// Shared multiply-accumulate unit: registered 16x16 multiply, 35-bit accumulate.
module mme_mac
	import mme_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_s1,
	input  term_tag_t               tag_s1,
	input  logic signed [VAL_W-1:0] a_s1,
	input  logic signed [VAL_W-1:0] b_s1,
	output logic                    done,
	output term_tag_t               done_tag,
	output logic signed [SUM_W-1:0] sum
);

	logic                     vld_s2;
	term_tag_t                tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2  <= tag_s1;
			prod_s2 <= a_s1 * b_s1;
		end
	end

	assign base = tag_s2.first ? '0 : acc_q;
	assign sum  = base + {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (en && vld_s2) begin
			acc_q <= sum;
		end
	end

	assign done     = vld_s2 && tag_s2.last_k;
	assign done_tag = tag_s2;

endmodule

[rtl/matrix_multiply_engine.sv]
// Top level of the matrix multiply engine: stores, sequencer and result register.
//
// Channel   Direction  Beat carries
// s_axis    in         tuser: func; tdata: row_index, column_index, element_value
// m_axis    out        tdata: product_row, product_column, product_value; tlast
// cfg       in         cfg_we / cfg_index / cfg_data, one register per write
//
// A load beat leaves tready high.
// A compute beat issues left_rows * right_columns * inner_length terms through
// the single multiplier; tready is low while terms are issued.
// A stalled m_axis freezes the whole multiply-accumulate pipe (RAM reads included).
// Reset clears control and the dimension registers (all to 8); the stores are
// not cleared and must be loaded before use.
module matrix_multiply_engine
	import mme_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// slave stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // [2:0] row_index, [5:3] column_index,
	                                            // [21:6] element_value, [23:22] zero
	input  logic [FUNC_W-1:0]    s_axis_tuser,  // [1:0] func
	// master stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [47:0]          m_axis_tdata,  // [2:0] product_row, [5:3] product_column,
	                                            // [40:6] product_value, [47:41] zero
	output logic                 m_axis_tlast,  // last_element
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'((MAX_DIM < IDX_LIMIT) ? MAX_DIM : IDX_LIMIT);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	// input beat unpacked
	logic [IDX_W-1:0] in_row;
	logic [IDX_W-1:0] in_col;
	logic [VAL_W-1:0] in_val;
	logic             in_acc;
	logic             in_range;
	logic [ADDR_W-1:0] wr_addr;

	assign in_row = s_axis_tdata[2:0];
	assign in_col = s_axis_tdata[5:3];
	assign in_val = s_axis_tdata[21:6];
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
	assign wr_addr = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);

	// dimension registers
	logic [DIM_W-1:0] rows_q, inner_q, cols_q;
	logic [DIM_W-1:0] rows_eff, inner_eff, cols_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_RESET;
			inner_q <= DIM_RESET;
			cols_q  <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_ROWS:     rows_q  <= cfg_data;
				REG_INNER_LENGTH:  inner_q <= cfg_data;
				REG_RIGHT_COLUMNS: cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rows_eff  = eff_dim(rows_q, DIM_LIM);
	assign inner_eff = eff_dim(inner_q, DIM_LIM);
	assign cols_eff  = eff_dim(cols_q, DIM_LIM);

	// pipe advance: held only while a result waits and is not taken
	logic out_valid_q;
	logic adv;
	assign adv = !out_valid_q || m_axis_tready;

	// term sequencer: walks r, c, k and issues one term per advancing cycle
	logic             state_q;
	logic [IDX_W-1:0] r_q, c_q, k_q;
	logic             k_end, c_end, r_end;
	logic             issue;
	term_tag_t        tag_s0;

	assign k_end = {1'b0, k_q} == inner_eff - 4'd1;
	assign c_end = {1'b0, c_q} == cols_eff - 4'd1;
	assign r_end = {1'b0, r_q} == rows_eff - 4'd1;
	assign issue = (state_q == ST_RUN) && adv;

	assign tag_s0.first   = k_q == '0;
	assign tag_s0.last_k  = k_end;
	assign tag_s0.last_el = k_end && c_end && r_end;
	assign tag_s0.row     = r_q;
	assign tag_s0.col     = c_q;

	assign s_axis_tready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && s_axis_tuser == FUNC_COMPUTE) begin
						state_q <= ST_RUN;
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (!k_end) begin
							k_q <= k_q + 3'd1;
						end else begin
							k_q <= '0;
							if (!c_end) begin
								c_q <= c_q + 3'd1;
							end else begin
								c_q <= '0;
								if (!r_end) begin
									r_q <= r_q + 3'd1;
								end else begin
									state_q <= ST_IDLE;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stores: left read at row r / column k, right at row k / column c
	logic [ADDR_W-1:0] left_raddr, right_raddr;
	logic [VAL_W-1:0]  left_rdata, right_rdata;

	assign left_raddr  = ADDR_W'(r_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
	assign right_raddr = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(c_q);

	mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_left_store (
		.clk   (clk),
		.we    (in_acc && s_axis_tuser == FUNC_LOAD_LEFT && in_range),
		.waddr (wr_addr),
		.wdata (in_val),
		.re    (adv),
		.raddr (left_raddr),
		.rdata (left_rdata)
	);

	mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_right_store (
		.clk   (clk),
		.we    (in_acc && s_axis_tuser == FUNC_LOAD_RIGHT && in_range),
		.waddr (wr_addr),
		.wdata (in_val),
		.re    (adv),
		.raddr (right_raddr),
		.rdata (right_rdata)
	);

	// stage 1: tag lines up with registered RAM data
	logic      vld_s1;
	term_tag_t tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_s0;
		end
	end

	// shared multiply-accumulate
	logic                    mac_done;
	term_tag_t               mac_tag;
	logic signed [SUM_W-1:0] mac_sum;

	mme_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_s1   (vld_s1),
		.tag_s1   (tag_s1),
		.a_s1     ($signed(left_rdata)),
		.b_s1     ($signed(right_rdata)),
		.done     (mac_done),
		.done_tag (mac_tag),
		.sum      (mac_sum)
	);

	// result register
	logic [IDX_W-1:0] out_row_q, out_col_q;
	logic [SUM_W-1:0] out_val_q;
	logic             out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && mac_done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && mac_done) begin
			out_row_q  <= mac_tag.row;
			out_col_q  <= mac_tag.col;
			out_val_q  <= mac_sum;
			out_last_q <= mac_tag.last_el;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_val_q, out_col_q, out_row_q};
	assign m_axis_tlast  = out_last_q;

endmodule

[rtl/matrix_multiply_engine_checker.sv]
// Port-level checker for the matrix multiply engine, bound to the top level.
`include "matrix_multiply_engine_assert.svh"

module matrix_multiply_engine_checker
	import mme_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [FUNC_W-1:0]    s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [47:0]          m_axis_tdata,
	input logic                 m_axis_tlast
);

	// a result held back keeps its beat intact
	`MME_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
		"result beat changed while stalled")

	// a compute beat closes the input side
	`MME_ASSERT_NEXT(a_compute_busy,
		s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_COMPUTE,
		!s_axis_tready, "input still open after a compute beat")

	// loads and unused codes leave the input side open
	`MME_ASSERT_NEXT(a_load_single,
		s_axis_tvalid && s_axis_tready && s_axis_tuser != FUNC_COMPUTE,
		s_axis_tready, "input closed after a load beat")

	// padding bits of the result beat stay zero
	`MME_ASSERT_NOW(a_out_pad, m_axis_tvalid, m_axis_tdata[47:41] == 7'd0,
		"result padding not zero")

endmodule

bind matrix_multiply_engine matrix_multiply_engine_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
